@@ hdl/escm_pkg.sv @@
// ----------------------------------------------------------------------------
// escm_pkg
// Shared types, widths and codes for the element sparsity to CSR map block.
// ----------------------------------------------------------------------------
package escm_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int MAX_LIST     = 4096;
  localparam int MAX_PAIRS    = 16384;
  localparam int MAX_ROWS     = 4096;
  localparam int MAX_COLUMNS  = 4096;

  localparam int DOF_W      = 12;                       // one row or column index
  localparam int CNT_W      = 13;                       // counts up to 4096
  localparam int PTR_W      = 15;                       // counts up to 16384
  localparam int ELEM_W     = 9;                        // element count up to 256
  localparam int LIST_AW    = 12;
  localparam int OFFS_DEPTH = MAX_ELEMENTS + 1;
  localparam int OFFS_AW    = 9;
  localparam int PAIR_AW    = 14;
  localparam int RP_DEPTH   = MAX_ROWS + 1;
  localparam int RP_AW      = 13;
  localparam int KEY_W      = 2 * DOF_W + PAIR_AW;     // {row, column, source pair}

  // request codes
  localparam logic [2:0] REQ_ADD_ROW = 3'd0;
  localparam logic [2:0] REQ_ADD_COL = 3'd1;
  localparam logic [2:0] REQ_CLOSE   = 3'd2;
  localparam logic [2:0] REQ_BUILD   = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;
  localparam logic [2:0] REQ_CLEAR   = 3'd5;

  // table selectors
  localparam logic [3:0] TBL_ROW_OFFS  = 4'd0;
  localparam logic [3:0] TBL_ROWS      = 4'd1;
  localparam logic [3:0] TBL_COL_OFFS  = 4'd2;
  localparam logic [3:0] TBL_COLS      = 4'd3;
  localparam logic [3:0] TBL_PAIR_OFFS = 4'd4;
  localparam logic [3:0] TBL_SLOT_MAP  = 4'd5;
  localparam logic [3:0] TBL_ROW_PTRS  = 4'd6;
  localparam logic [3:0] TBL_SLOT_COLS = 4'd7;
  localparam logic [3:0] TBL_MAXIMA    = 4'd8;
  localparam logic [3:0] TBL_COUNTS    = 4'd9;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_RANGE      = 3'd1;
  localparam logic [2:0] ST_CAPACITY   = 3'd2;
  localparam logic [2:0] ST_READ_RANGE = 3'd3;
  localparam logic [2:0] ST_NOT_BUILT  = 3'd4;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT = 1'b0;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [DOF_W-1:0] dof_index;
    logic [3:0]       table_select;
    logic [PTR_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [PTR_W-1:0] read_value;
    logic [2:0]       status;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic               is_col;
    logic [LIST_AW-1:0] addr;
    logic [DOF_W-1:0]   data;
  } list_wr_t;

  typedef struct packed {
    logic               en;
    logic [OFFS_AW-1:0] addr;
    logic [CNT_W-1:0]   row;
    logic [CNT_W-1:0]   col;
    logic [PTR_W-1:0]   pair;
  } offs_wr_t;

  typedef struct packed {
    logic               en;
    logic               bank;
    logic [PAIR_AW-1:0] addr;
    logic [KEY_W-1:0]   data;
  } pair_wr_t;

  typedef struct packed {
    logic               map_en;
    logic [PAIR_AW-1:0] map_addr;
    logic [PAIR_AW-1:0] map_data;
    logic               rp_en;
    logic [RP_AW-1:0]   rp_addr;
    logic [PTR_W-1:0]   rp_data;
    logic               col_en;
    logic [PAIR_AW-1:0] col_addr;
    logic [DOF_W-1:0]   col_data;
  } csr_wr_t;

endpackage

@@ hdl/escm_list_mem.sv @@
// ----------------------------------------------------------------------------
// escm_list_mem
// Index lists and per-element offset tables, with registered reads.
// ----------------------------------------------------------------------------
module escm_list_mem (
  input  logic                          clk,
  input  escm_pkg::list_wr_t            list_wr,
  input  logic [escm_pkg::LIST_AW-1:0]  row_raddr,
  input  logic [escm_pkg::LIST_AW-1:0]  col_raddr,
  output logic [escm_pkg::DOF_W-1:0]    row_rdata,
  output logic [escm_pkg::DOF_W-1:0]    col_rdata,
  input  escm_pkg::offs_wr_t            offs_wr,
  input  logic [escm_pkg::OFFS_AW-1:0]  offs_raddr,
  output logic [escm_pkg::CNT_W-1:0]    offs_row_rdata,
  output logic [escm_pkg::CNT_W-1:0]    offs_col_rdata,
  output logic [escm_pkg::PTR_W-1:0]    offs_pair_rdata
);

  logic [escm_pkg::DOF_W-1:0] row_list [escm_pkg::MAX_LIST];
  logic [escm_pkg::DOF_W-1:0] col_list [escm_pkg::MAX_LIST];
  logic [escm_pkg::CNT_W-1:0] row_offs [escm_pkg::OFFS_DEPTH];
  logic [escm_pkg::CNT_W-1:0] col_offs [escm_pkg::OFFS_DEPTH];
  logic [escm_pkg::PTR_W-1:0] pair_offs [escm_pkg::OFFS_DEPTH];

  always_ff @(posedge clk) begin
    if (list_wr.en && !list_wr.is_col) begin
      row_list[list_wr.addr] <= list_wr.data;
    end
    row_rdata <= row_list[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_wr.en && list_wr.is_col) begin
      col_list[list_wr.addr] <= list_wr.data;
    end
    col_rdata <= col_list[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (offs_wr.en) begin
      row_offs[offs_wr.addr]  <= offs_wr.row;
      col_offs[offs_wr.addr]  <= offs_wr.col;
      pair_offs[offs_wr.addr] <= offs_wr.pair;
    end
    offs_row_rdata  <= row_offs[offs_raddr];
    offs_col_rdata  <= col_offs[offs_raddr];
    offs_pair_rdata <= pair_offs[offs_raddr];
  end

endmodule

@@ hdl/escm_pair_mem.sv @@
// ----------------------------------------------------------------------------
// escm_pair_mem
// Two banks of pair keys for ping-pong merge passes; two read ports.
// ----------------------------------------------------------------------------
module escm_pair_mem (
  input  logic                          clk,
  input  escm_pkg::pair_wr_t            pair_wr,
  input  logic                          rd_bank,
  input  logic [escm_pkg::PAIR_AW-1:0]  rd_addr_a,
  input  logic [escm_pkg::PAIR_AW-1:0]  rd_addr_b,
  output logic [escm_pkg::KEY_W-1:0]    rd_data_a,
  output logic [escm_pkg::KEY_W-1:0]    rd_data_b
);

  logic [escm_pkg::KEY_W-1:0] bank0 [escm_pkg::MAX_PAIRS];
  logic [escm_pkg::KEY_W-1:0] bank1 [escm_pkg::MAX_PAIRS];
  logic [escm_pkg::KEY_W-1:0] b0_a, b0_b, b1_a, b1_b;
  logic                       bank_q;

  always_ff @(posedge clk) begin
    if (pair_wr.en && !pair_wr.bank) begin
      bank0[pair_wr.addr] <= pair_wr.data;
    end
    b0_a <= bank0[rd_addr_a];
    b0_b <= bank0[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (pair_wr.en && pair_wr.bank) begin
      bank1[pair_wr.addr] <= pair_wr.data;
    end
    b1_a <= bank1[rd_addr_a];
    b1_b <= bank1[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    bank_q <= rd_bank;
  end

  assign rd_data_a = bank_q ? b1_a : b0_a;
  assign rd_data_b = bank_q ? b1_b : b0_b;

endmodule

@@ hdl/escm_csr_mem.sv @@
// ----------------------------------------------------------------------------
// escm_csr_mem
// Built CSR tables: pair-to-slot map, row pointers and slot columns.
// ----------------------------------------------------------------------------
module escm_csr_mem (
  input  logic                          clk,
  input  escm_pkg::csr_wr_t             csr_wr,
  input  logic [escm_pkg::PTR_W-1:0]    raddr,
  output logic [escm_pkg::PAIR_AW-1:0]  map_rdata,
  output logic [escm_pkg::PTR_W-1:0]    rp_rdata,
  output logic [escm_pkg::DOF_W-1:0]    col_rdata
);

  logic [escm_pkg::PAIR_AW-1:0] slot_map  [escm_pkg::MAX_PAIRS];
  logic [escm_pkg::PTR_W-1:0]   row_ptrs  [escm_pkg::RP_DEPTH];
  logic [escm_pkg::DOF_W-1:0]   slot_cols [escm_pkg::MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (csr_wr.map_en) begin
      slot_map[csr_wr.map_addr] <= csr_wr.map_data;
    end
    map_rdata <= slot_map[raddr[escm_pkg::PAIR_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (csr_wr.rp_en) begin
      row_ptrs[csr_wr.rp_addr] <= csr_wr.rp_data;
    end
    rp_rdata <= row_ptrs[raddr[escm_pkg::RP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (csr_wr.col_en) begin
      slot_cols[csr_wr.col_addr] <= csr_wr.col_data;
    end
    col_rdata <= slot_cols[raddr[escm_pkg::PAIR_AW-1:0]];
  end

endmodule

@@ hdl/element_sparsity_to_csr_map.sv @@
// ----------------------------------------------------------------------------
// element_sparsity_to_csr_map
// Add, clear, register-read and rejected requests answer from idle, close from
// S_CLOSE, table reads from S_READ_DATA. Requests are taken only while idle;
// a stalled response holds the block in S_EMIT. Build time grows with list
// entries, pairs, unique slots and row_count, mostly merge passes over the two
// pair banks. Reset is synchronous; all memories need no clearing.
// ----------------------------------------------------------------------------
module element_sparsity_to_csr_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  escm_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output escm_pkg::rsp_t              rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [escm_pkg::CNT_W-1:0]  cfg_data
);

  // sequencer states
  localparam logic [4:0] S_IDLE          = 5'd0;
  localparam logic [4:0] S_EMIT          = 5'd1;
  localparam logic [4:0] S_READ_DATA     = 5'd2;
  localparam logic [4:0] S_CLOSE         = 5'd3;
  localparam logic [4:0] S_CHK_ROW_RD    = 5'd4;
  localparam logic [4:0] S_CHK_ROW_TEST  = 5'd5;
  localparam logic [4:0] S_CHK_COL_RD    = 5'd6;
  localparam logic [4:0] S_CHK_COL_TEST  = 5'd7;
  localparam logic [4:0] S_GEN_ELEM      = 5'd8;
  localparam logic [4:0] S_GEN_ELEM_WAIT = 5'd9;
  localparam logic [4:0] S_GEN_RD        = 5'd10;
  localparam logic [4:0] S_GEN_WR        = 5'd11;
  localparam logic [4:0] S_SORT_PASS     = 5'd12;
  localparam logic [4:0] S_SORT_RUN      = 5'd13;
  localparam logic [4:0] S_SORT_RD       = 5'd14;
  localparam logic [4:0] S_SORT_WR       = 5'd15;
  localparam logic [4:0] S_SCAN_RD       = 5'd16;
  localparam logic [4:0] S_SCAN_PROC     = 5'd17;
  localparam logic [4:0] S_FILL          = 5'd18;

  localparam int CNT_W   = escm_pkg::CNT_W;
  localparam int PTR_W   = escm_pkg::PTR_W;
  localparam int ELEM_W  = escm_pkg::ELEM_W;
  localparam int DOF_W   = escm_pkg::DOF_W;
  localparam int KEY_W   = escm_pkg::KEY_W;
  localparam int PAIR_AW = escm_pkg::PAIR_AW;
  localparam int LIST_AW = escm_pkg::LIST_AW;
  localparam int OFFS_AW = escm_pkg::OFFS_AW;
  localparam int PROD_W  = 2 * CNT_W;

  localparam logic [CNT_W-1:0]  LIST_CAP  = CNT_W'(escm_pkg::MAX_LIST);
  localparam logic [CNT_W-1:0]  ROW_CAP   = CNT_W'(escm_pkg::MAX_ROWS);
  localparam logic [CNT_W-1:0]  COL_CAP   = CNT_W'(escm_pkg::MAX_COLUMNS);
  localparam logic [ELEM_W-1:0] ELEM_CAP  = ELEM_W'(escm_pkg::MAX_ELEMENTS);
  localparam logic [PROD_W:0]   PAIR_CAP  = (PROD_W+1)'(escm_pkg::MAX_PAIRS);

  logic [4:0] state;

  // configuration registers
  logic [CNT_W-1:0] row_count, column_count;

  // loading state; row_total etc. mirror the offset table entry of element_count
  logic [ELEM_W-1:0] element_count;
  logic [CNT_W-1:0]  open_rows, open_cols;
  logic [CNT_W-1:0]  row_total, col_total;
  logic [PTR_W-1:0]  pair_total;
  logic [PTR_W-1:0]  uniq_count;
  logic [CNT_W-1:0]  max_rows, max_cols;
  logic [PTR_W-1:0]  max_pairs;
  logic              error_flag, built_flag;
  logic [PROD_W-1:0] prod;

  // read request capture
  logic [3:0]        rd_sel;
  logic [PTR_W-1:0]  rd_idx;

  // build walkers
  logic [PTR_W-1:0]  walk;
  logic [ELEM_W-1:0] e_idx;
  logic [CNT_W-1:0]  r_pos, c_pos, r_end, c_end, r_base, c_base;
  logic [PTR_W-1:0]  k_pos;
  logic [PTR_W-1:0]  width, lo, mid, hi, a_pos, b_pos;
  logic              src_sel;
  logic [CNT_W-1:0]  w_row;
  logic [PTR_W-1:0]  uniq;
  logic [2*DOF_W-1:0] prev_key;
  logic              first;
  escm_pkg::rsp_t    hold;

  // memory ports
  escm_pkg::list_wr_t list_wr;
  escm_pkg::offs_wr_t offs_wr;
  escm_pkg::pair_wr_t pair_wr;
  escm_pkg::csr_wr_t  csr_wr;
  logic [LIST_AW-1:0] row_raddr, col_raddr;
  logic [DOF_W-1:0]   row_rdata, col_rdata;
  logic [OFFS_AW-1:0] offs_raddr;
  logic [CNT_W-1:0]   offs_row_rdata, offs_col_rdata;
  logic [PTR_W-1:0]   offs_pair_rdata;
  logic [PAIR_AW-1:0] pair_addr_a, pair_addr_b;
  logic [KEY_W-1:0]   pair_rd_a, pair_rd_b;
  logic [PAIR_AW-1:0] map_rdata;
  logic [PTR_W-1:0]   rp_rdata;
  logic [DOF_W-1:0]   scol_rdata;

  logic accept;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // ---------------------------------------------------------------- add path
  logic [CNT_W-1:0] row_fill, col_fill, add_limit, add_fill;
  logic             add_is_col;
  logic [2:0]       add_status;

  assign row_fill   = row_total + open_rows;
  assign col_fill   = col_total + open_cols;
  assign add_is_col = (req.req_type == escm_pkg::REQ_ADD_COL);
  assign add_limit  = add_is_col ? column_count : row_count;
  assign add_fill   = add_is_col ? col_fill : row_fill;

  always_comb begin
    if ({1'b0, req.dof_index} >= add_limit) begin
      add_status = escm_pkg::ST_RANGE;
    end else if (add_fill >= LIST_CAP) begin
      add_status = escm_pkg::ST_CAPACITY;
    end else begin
      add_status = escm_pkg::ST_OK;
    end
  end

  // -------------------------------------------------------------- close path
  logic [PROD_W:0] close_sum;
  logic            close_bad;
  assign close_sum = {{(PROD_W+1-PTR_W){1'b0}}, pair_total} + {1'b0, prod};
  assign close_bad = (element_count >= ELEM_CAP) || (close_sum > PAIR_CAP);

  logic cnt_over;
  assign cnt_over = (row_count > ROW_CAP) || (column_count > COL_CAP);

  // --------------------------------------------------------- read decoding
  logic [PTR_W-1:0] rd_limit;
  logic             rd_known, rd_needs_built, rd_from_regs;
  logic [2:0]       rd_status;
  logic [PTR_W-1:0] reg_value;

  always_comb begin
    rd_limit       = '0;
    rd_known       = 1'b1;
    rd_needs_built = 1'b0;
    rd_from_regs   = 1'b0;
    case (req.table_select) inside
      escm_pkg::TBL_ROW_OFFS, escm_pkg::TBL_COL_OFFS, escm_pkg::TBL_PAIR_OFFS: begin
        rd_limit = PTR_W'(element_count) + PTR_W'(1);
      end
      escm_pkg::TBL_ROWS:     rd_limit = PTR_W'(row_fill);
      escm_pkg::TBL_COLS:     rd_limit = PTR_W'(col_fill);
      escm_pkg::TBL_SLOT_MAP: begin
        rd_limit       = pair_total;
        rd_needs_built = 1'b1;
      end
      escm_pkg::TBL_ROW_PTRS: begin
        rd_limit       = PTR_W'(row_count) + PTR_W'(1);
        rd_needs_built = 1'b1;
      end
      escm_pkg::TBL_SLOT_COLS: begin
        rd_limit       = uniq_count;
        rd_needs_built = 1'b1;
      end
      escm_pkg::TBL_MAXIMA, escm_pkg::TBL_COUNTS: begin
        rd_limit     = PTR_W'(3);
        rd_from_regs = 1'b1;
      end
      default: rd_known = 1'b0;
    endcase

    if (!rd_known) begin
      rd_status = escm_pkg::ST_READ_RANGE;
    end else if (rd_needs_built && !built_flag) begin
      rd_status = escm_pkg::ST_NOT_BUILT;
    end else if (req.read_index >= rd_limit) begin
      rd_status = escm_pkg::ST_READ_RANGE;
    end else begin
      rd_status = escm_pkg::ST_OK;
    end

    // maxima and counts come straight from registers
    reg_value = '0;
    if (req.table_select == escm_pkg::TBL_MAXIMA) begin
      case (req.read_index[1:0])
        2'd0:    reg_value = PTR_W'(max_rows);
        2'd1:    reg_value = PTR_W'(max_cols);
        default: reg_value = max_pairs;
      endcase
    end else begin
      case (req.read_index[1:0])
        2'd0:    reg_value = PTR_W'(element_count);
        2'd1:    reg_value = pair_total;
        default: reg_value = uniq_count;
      endcase
    end
  end

  // table word once the memory data is back
  logic [PTR_W-1:0] mem_value;
  always_comb begin
    case (rd_sel)
      escm_pkg::TBL_ROW_OFFS:  mem_value = (rd_idx == '0) ? '0 : PTR_W'(offs_row_rdata);
      escm_pkg::TBL_ROWS:      mem_value = PTR_W'(row_rdata);
      escm_pkg::TBL_COL_OFFS:  mem_value = (rd_idx == '0) ? '0 : PTR_W'(offs_col_rdata);
      escm_pkg::TBL_COLS:      mem_value = PTR_W'(col_rdata);
      escm_pkg::TBL_PAIR_OFFS: mem_value = (rd_idx == '0) ? '0 : offs_pair_rdata;
      escm_pkg::TBL_SLOT_MAP:  mem_value = PTR_W'(map_rdata);
      escm_pkg::TBL_ROW_PTRS:  mem_value = rp_rdata;
      escm_pkg::TBL_SLOT_COLS: mem_value = PTR_W'(scol_rdata);
      default:                 mem_value = '0;
    endcase
  end

  // ---------------------------------------------------------- build helpers
  logic             chk_row_bad, chk_col_bad;
  assign chk_row_bad = ({1'b0, row_rdata} >= row_count);
  assign chk_col_bad = ({1'b0, col_rdata} >= column_count);

  logic [PTR_W-1:0] lo_w, mid_v, mid_w, hi_v;
  assign lo_w  = lo + width;
  assign mid_v = (lo_w < pair_total) ? lo_w : pair_total;
  assign mid_w = mid_v + width;
  assign hi_v  = (mid_w < pair_total) ? mid_w : pair_total;

  logic take_a;
  assign take_a = (a_pos < mid) && ((b_pos >= hi) || (pair_rd_a <= pair_rd_b));

  // sorted key fields: {row, column, source pair}
  logic [DOF_W-1:0]   scan_row, scan_col;
  logic [PAIR_AW-1:0] scan_src;
  logic               scan_new, scan_fill;
  assign scan_row  = pair_rd_a[KEY_W-1 -: DOF_W];
  assign scan_col  = pair_rd_a[PAIR_AW +: DOF_W];
  assign scan_src  = pair_rd_a[PAIR_AW-1:0];
  assign scan_new  = first || (pair_rd_a[KEY_W-1:PAIR_AW] != prev_key);
  // rows up to this one still lack a pointer: write them before taking the slot
  assign scan_fill = scan_new && (w_row <= {1'b0, scan_row});

  // ---------------------------------------------------------- result select
  logic           fin_en;
  escm_pkg::rsp_t fin_rsp;

  always_comb begin
    fin_en  = 1'b0;
    fin_rsp = '{read_value: '0, status: escm_pkg::ST_OK};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type) inside
            escm_pkg::REQ_ADD_ROW, escm_pkg::REQ_ADD_COL: begin
              fin_en         = 1'b1;
              fin_rsp.status = add_status;
            end
            escm_pkg::REQ_CLOSE: fin_en = 1'b0;
            escm_pkg::REQ_BUILD: begin
              if (error_flag) begin
                fin_en         = 1'b1;
                fin_rsp.status = escm_pkg::ST_NOT_BUILT;
              end else if (cnt_over) begin
                fin_en         = 1'b1;
                fin_rsp.status = escm_pkg::ST_CAPACITY;
              end
            end
            escm_pkg::REQ_READ: begin
              if (rd_status != escm_pkg::ST_OK) begin
                fin_en         = 1'b1;
                fin_rsp.status = rd_status;
              end else if (rd_from_regs) begin
                fin_en             = 1'b1;
                fin_rsp.read_value = reg_value;
              end
            end
            default: fin_en = 1'b1;   // clear and unused codes answer ok
          endcase
        end
      end
      S_READ_DATA: begin
        fin_en             = 1'b1;
        fin_rsp.read_value = mem_value;
      end
      S_CLOSE: begin
        fin_en         = 1'b1;
        fin_rsp.status = close_bad ? escm_pkg::ST_CAPACITY : escm_pkg::ST_OK;
      end
      S_CHK_ROW_TEST: begin
        fin_en         = chk_row_bad;
        fin_rsp.status = escm_pkg::ST_RANGE;
      end
      S_CHK_COL_TEST: begin
        fin_en         = chk_col_bad;
        fin_rsp.status = escm_pkg::ST_RANGE;
      end
      S_FILL: begin
        fin_en             = (w_row > row_count);
        fin_rsp.read_value = pair_total;
      end
      default: fin_en = 1'b0;
    endcase
  end

  // ------------------------------------------------------------ memory ports
  always_comb begin
    list_wr.en     = accept && (req.req_type == escm_pkg::REQ_ADD_ROW ||
                                req.req_type == escm_pkg::REQ_ADD_COL) &&
                     (add_status == escm_pkg::ST_OK);
    list_wr.is_col = add_is_col;
    list_wr.addr   = add_fill[LIST_AW-1:0];
    list_wr.data   = req.dof_index;

    offs_wr.en   = (state == S_CLOSE) && !close_bad;
    offs_wr.addr = element_count + ELEM_W'(1);
    offs_wr.row  = row_fill;
    offs_wr.col  = col_fill;
    offs_wr.pair = pair_total + prod[PTR_W-1:0];

    row_raddr  = req.read_index[LIST_AW-1:0];
    col_raddr  = req.read_index[LIST_AW-1:0];
    offs_raddr = req.read_index[OFFS_AW-1:0];
    case (state) inside
      S_CHK_ROW_RD, S_CHK_ROW_TEST, S_CHK_COL_RD, S_CHK_COL_TEST: begin
        row_raddr = walk[LIST_AW-1:0];
        col_raddr = walk[LIST_AW-1:0];
      end
      S_GEN_RD, S_GEN_WR: begin
        row_raddr = r_pos[LIST_AW-1:0];
        col_raddr = c_pos[LIST_AW-1:0];
      end
      S_GEN_ELEM, S_GEN_ELEM_WAIT: offs_raddr = e_idx + ELEM_W'(1);
      default: ;
    endcase

    pair_wr.en   = 1'b0;
    pair_wr.bank = 1'b0;
    pair_wr.addr = k_pos[PAIR_AW-1:0];
    pair_wr.data = {row_rdata, col_rdata, k_pos[PAIR_AW-1:0]};
    if (state == S_GEN_WR) begin
      pair_wr.en = 1'b1;
    end else if (state == S_SORT_WR) begin
      pair_wr.en   = 1'b1;
      pair_wr.bank = ~src_sel;
      pair_wr.data = take_a ? pair_rd_a : pair_rd_b;
    end

    if (state == S_SCAN_RD || state == S_SCAN_PROC) begin
      pair_addr_a = walk[PAIR_AW-1:0];
    end else begin
      pair_addr_a = a_pos[PAIR_AW-1:0];
    end
    pair_addr_b = b_pos[PAIR_AW-1:0];

    csr_wr.map_en   = (state == S_SCAN_PROC) && !scan_fill;
    csr_wr.map_addr = scan_src;
    csr_wr.map_data = scan_new ? uniq[PAIR_AW-1:0] : (uniq[PAIR_AW-1:0] - PAIR_AW'(1));
    csr_wr.rp_en    = ((state == S_SCAN_PROC) && scan_fill) ||
                      ((state == S_FILL) && (w_row <= row_count));
    csr_wr.rp_addr  = w_row;
    csr_wr.rp_data  = uniq;
    csr_wr.col_en   = (state == S_SCAN_PROC) && !scan_fill && scan_new;
    csr_wr.col_addr = uniq[PAIR_AW-1:0];
    csr_wr.col_data = scan_col;
  end

  // --------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row_count     <= '0;
      column_count  <= '0;
      element_count <= '0;
      open_rows     <= '0;
      open_cols     <= '0;
      row_total     <= '0;
      col_total     <= '0;
      pair_total    <= '0;
      uniq_count    <= '0;
      max_rows      <= '0;
      max_cols      <= '0;
      max_pairs     <= '0;
      error_flag    <= 1'b0;
      built_flag    <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == escm_pkg::CFG_ROW_COUNT) begin
          row_count <= cfg_data;
        end else begin
          column_count <= cfg_data;
        end
        built_flag <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.req_type) inside
              escm_pkg::REQ_ADD_ROW, escm_pkg::REQ_ADD_COL: begin
                if (add_status != escm_pkg::ST_OK) begin
                  error_flag <= 1'b1;
                end else begin
                  if (add_is_col) begin
                    open_cols <= open_cols + CNT_W'(1);
                  end else begin
                    open_rows <= open_rows + CNT_W'(1);
                  end
                  built_flag <= 1'b0;
                end
              end
              escm_pkg::REQ_CLOSE: begin
                prod       <= open_rows * open_cols;
                built_flag <= 1'b0;
                state      <= S_CLOSE;
              end
              escm_pkg::REQ_BUILD: begin
                built_flag <= 1'b0;
                if (!error_flag) begin
                  if (cnt_over) begin
                    error_flag <= 1'b1;
                  end else begin
                    walk  <= '0;
                    state <= S_CHK_ROW_RD;
                  end
                end
              end
              escm_pkg::REQ_READ: begin
                rd_sel <= req.table_select;
                rd_idx <= req.read_index;
                if (rd_status == escm_pkg::ST_OK && !rd_from_regs) begin
                  state <= S_READ_DATA;
                end
              end
              escm_pkg::REQ_CLEAR: begin
                element_count <= '0;
                open_rows     <= '0;
                open_cols     <= '0;
                row_total     <= '0;
                col_total     <= '0;
                pair_total    <= '0;
                uniq_count    <= '0;
                max_rows      <= '0;
                max_cols      <= '0;
                max_pairs     <= '0;
                error_flag    <= 1'b0;
                built_flag    <= 1'b0;
              end
              default: ;
            endcase
          end
        end

        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= hold;
            state     <= S_IDLE;
          end
        end

        S_READ_DATA: ;

        S_CLOSE: begin
          if (close_bad) begin
            error_flag <= 1'b1;
          end else begin
            row_total     <= row_fill;
            col_total     <= col_fill;
            pair_total    <= pair_total + prod[PTR_W-1:0];
            if (open_rows > max_rows) max_rows <= open_rows;
            if (open_cols > max_cols) max_cols <= open_cols;
            if (prod[PTR_W-1:0] > max_pairs) max_pairs <= prod[PTR_W-1:0];
            element_count <= element_count + ELEM_W'(1);
            open_rows     <= '0;
            open_cols     <= '0;
          end
        end

        // every stored index must still be below its count
        S_CHK_ROW_RD: begin
          if (walk == PTR_W'(row_total)) begin
            walk  <= '0;
            state <= S_CHK_COL_RD;
          end else begin
            state <= S_CHK_ROW_TEST;
          end
        end
        S_CHK_ROW_TEST: begin
          if (chk_row_bad) begin
            error_flag <= 1'b1;
          end else begin
            walk  <= walk + PTR_W'(1);
            state <= S_CHK_ROW_RD;
          end
        end
        S_CHK_COL_RD: begin
          if (walk == PTR_W'(col_total)) begin
            e_idx  <= '0;
            r_base <= '0;
            c_base <= '0;
            k_pos  <= '0;
            state  <= S_GEN_ELEM;
          end else begin
            state <= S_CHK_COL_TEST;
          end
        end
        S_CHK_COL_TEST: begin
          if (chk_col_bad) begin
            error_flag <= 1'b1;
          end else begin
            walk  <= walk + PTR_W'(1);
            state <= S_CHK_COL_RD;
          end
        end

        // pair generation, element by element, into bank 0
        S_GEN_ELEM: begin
          if (e_idx == element_count) begin
            width   <= PTR_W'(1);
            src_sel <= 1'b0;
            state   <= S_SORT_PASS;
          end else begin
            state <= S_GEN_ELEM_WAIT;
          end
        end
        S_GEN_ELEM_WAIT: begin
          r_end <= offs_row_rdata;
          c_end <= offs_col_rdata;
          if (offs_row_rdata == r_base || offs_col_rdata == c_base) begin
            e_idx  <= e_idx + ELEM_W'(1);
            r_base <= offs_row_rdata;
            c_base <= offs_col_rdata;
            state  <= S_GEN_ELEM;
          end else begin
            r_pos <= r_base;
            c_pos <= c_base;
            state <= S_GEN_RD;
          end
        end
        S_GEN_RD: state <= S_GEN_WR;
        S_GEN_WR: begin
          k_pos <= k_pos + PTR_W'(1);
          if (c_pos + CNT_W'(1) == c_end) begin
            c_pos <= c_base;
            if (r_pos + CNT_W'(1) == r_end) begin
              e_idx  <= e_idx + ELEM_W'(1);
              r_base <= r_end;
              c_base <= c_end;
              state  <= S_GEN_ELEM;
            end else begin
              r_pos <= r_pos + CNT_W'(1);
              state <= S_GEN_RD;
            end
          end else begin
            c_pos <= c_pos + CNT_W'(1);
            state <= S_GEN_RD;
          end
        end

        // bottom-up merge sort, ping-pong between the two banks
        S_SORT_PASS: begin
          if (width >= pair_total) begin
            walk  <= '0;
            first <= 1'b1;
            uniq  <= '0;
            w_row <= '0;
            state <= S_SCAN_RD;
          end else begin
            lo    <= '0;
            state <= S_SORT_RUN;
          end
        end
        S_SORT_RUN: begin
          if (lo >= pair_total) begin
            src_sel <= ~src_sel;
            width   <= width << 1;
            state   <= S_SORT_PASS;
          end else begin
            mid   <= mid_v;
            hi    <= hi_v;
            a_pos <= lo;
            b_pos <= mid_v;
            k_pos <= lo;
            state <= S_SORT_RD;
          end
        end
        S_SORT_RD: begin
          if (k_pos >= hi) begin
            lo    <= hi;
            state <= S_SORT_RUN;
          end else begin
            state <= S_SORT_WR;
          end
        end
        S_SORT_WR: begin
          k_pos <= k_pos + PTR_W'(1);
          if (take_a) begin
            a_pos <= a_pos + PTR_W'(1);
          end else begin
            b_pos <= b_pos + PTR_W'(1);
          end
          state <= S_SORT_RD;
        end

        // merge duplicates, assign slots, lay down row pointers
        S_SCAN_RD: begin
          if (walk == pair_total) begin
            state <= S_FILL;
          end else begin
            state <= S_SCAN_PROC;
          end
        end
        S_SCAN_PROC: begin
          if (scan_fill) begin
            w_row <= w_row + CNT_W'(1);
          end else begin
            if (scan_new) begin
              uniq     <= uniq + PTR_W'(1);
              prev_key <= pair_rd_a[KEY_W-1:PAIR_AW];
            end
            first <= 1'b0;
            walk  <= walk + PTR_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_FILL: begin
          if (w_row > row_count) begin
            uniq_count <= uniq;
            built_flag <= 1'b1;
          end else begin
            w_row <= w_row + CNT_W'(1);
          end
        end

        default: state <= S_IDLE;
      endcase

      // result goes to the output register, or waits in hold while it is full
      if (fin_en) begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid <= 1'b1;
          rsp       <= fin_rsp;
          state     <= S_IDLE;
        end else begin
          hold  <= fin_rsp;
          state <= S_EMIT;
        end
      end
    end
  end

  // ------------------------------------------------------------------ stores
  escm_list_mem u_list_mem (
    .clk             (clk),
    .list_wr         (list_wr),
    .row_raddr       (row_raddr),
    .col_raddr       (col_raddr),
    .row_rdata       (row_rdata),
    .col_rdata       (col_rdata),
    .offs_wr         (offs_wr),
    .offs_raddr      (offs_raddr),
    .offs_row_rdata  (offs_row_rdata),
    .offs_col_rdata  (offs_col_rdata),
    .offs_pair_rdata (offs_pair_rdata)
  );

  escm_pair_mem u_pair_mem (
    .clk       (clk),
    .pair_wr   (pair_wr),
    .rd_bank   (src_sel),
    .rd_addr_a (pair_addr_a),
    .rd_addr_b (pair_addr_b),
    .rd_data_a (pair_rd_a),
    .rd_data_b (pair_rd_b)
  );

  escm_csr_mem u_csr_mem (
    .clk       (clk),
    .csr_wr    (csr_wr),
    .raddr     (req.read_index),
    .map_rdata (map_rdata),
    .rp_rdata  (rp_rdata),
    .col_rdata (scol_rdata)
  );

endmodule

@@ sim/element_sparsity_to_csr_map_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// element_sparsity_to_csr_map_tb
// Self-checking bench: loads element index lists, closes elements, builds the
// CSR tables and reads them back. Every response is checked field by field
// against an in-bench model of the map, under random idling on both channels.
// ----------------------------------------------------------------------------
module element_sparsity_to_csr_map_tb;
  import escm_pkg::*;

  // register index of the column count, next to the row count
  localparam logic       CFG_COL_COUNT = 1'b1;
  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_A   = 3'd6;
  localparam logic [2:0] REQ_SPARE_B   = 3'd7;
  // first selector past the last table
  localparam logic [3:0] TBL_NONE      = 4'd10;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  logic cfg_we;
  logic cfg_index;
  logic [CNT_W-1:0] cfg_data;

  element_sparsity_to_csr_map dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the map: registers, lists, offsets and built tables.
  // --------------------------------------------------------------------------
  int unsigned     sh_row_count, sh_col_count;
  int unsigned     sh_rows [MAX_LIST];
  int unsigned     sh_cols [MAX_LIST];
  int unsigned     sh_roffs[MAX_ELEMENTS+1];
  int unsigned     sh_coffs[MAX_ELEMENTS+1];
  int unsigned     sh_poffs[MAX_ELEMENTS+1];
  int unsigned     sh_slot_of_pair[MAX_PAIRS];
  int unsigned     sh_rptr [MAX_ROWS+1];
  int unsigned     sh_slot_col[MAX_PAIRS];
  longint unsigned sh_keys [MAX_PAIRS];
  int unsigned     sh_elems, sh_open_rows, sh_open_cols, sh_unique;
  int unsigned     sh_max [3];
  bit              sh_err, sh_built;

  rsp_t pending_rsp[$];   // responses owed by the block, oldest first
  int   fail_count = 0;
  int   sent_count = 0;
  bit   quiet = 1'b0;     // no idling on either side

  function automatic void map_clear();
    sh_roffs[0] = 0; sh_coffs[0] = 0; sh_poffs[0] = 0;
    sh_elems = 0; sh_open_rows = 0; sh_open_cols = 0; sh_unique = 0;
    sh_max[0] = 0; sh_max[1] = 0; sh_max[2] = 0;
    sh_err = 1'b0; sh_built = 1'b0;
  endfunction

  // Forms all element pairs as {row, column, source} keys, sorts them and
  // merges equal (row, column) into one slot.
  function automatic int unsigned map_build(output int unsigned value);
    int unsigned k, e, r, c, i, j, row;
    longint unsigned key, prev_id, id;
    k = 0; value = 0; prev_id = 0;
    if (sh_err) return ST_NOT_BUILT;
    if (sh_row_count > MAX_ROWS || sh_col_count > MAX_COLUMNS) begin
      sh_err = 1'b1;
      return ST_CAPACITY;
    end
    for (i = 0; i < sh_roffs[sh_elems]; i++)
      if (sh_rows[i] >= sh_row_count) begin sh_err = 1'b1; return ST_RANGE; end
    for (i = 0; i < sh_coffs[sh_elems]; i++)
      if (sh_cols[i] >= sh_col_count) begin sh_err = 1'b1; return ST_RANGE; end
    for (e = 0; e < sh_elems; e++)
      for (r = sh_roffs[e]; r < sh_roffs[e+1]; r++)
        for (c = sh_coffs[e]; c < sh_coffs[e+1]; c++) begin
          sh_keys[k] = (longint'(sh_rows[r]) << 26) | (longint'(sh_cols[c]) << 14) | k;
          k++;
        end
    // pair counts stay small, so plain insertion sort will do
    for (i = 1; i < k; i++) begin
      key = sh_keys[i];
      j = i;
      while (j > 0 && sh_keys[j-1] > key) begin
        sh_keys[j] = sh_keys[j-1];
        j--;
      end
      sh_keys[j] = key;
    end
    for (i = 0; i <= sh_row_count; i++) sh_rptr[i] = 0;
    sh_unique = 0;
    for (i = 0; i < k; i++) begin
      id  = sh_keys[i] >> 14;
      row = (sh_keys[i] >> 26) & 12'hFFF;
      if (i == 0 || id != prev_id) begin
        sh_slot_col[sh_unique] = (sh_keys[i] >> 14) & 12'hFFF;
        sh_unique++;
        sh_rptr[row+1]++;
      end
      prev_id = id;
      sh_slot_of_pair[sh_keys[i] & 14'h3FFF] = sh_unique - 1;
    end
    for (i = 0; i < sh_row_count; i++) sh_rptr[i+1] += sh_rptr[i];
    sh_built = 1'b1;
    value = sh_poffs[sh_elems];
    return ST_OK;
  endfunction

  function automatic int unsigned map_read(logic [3:0] sel, int unsigned idx,
                                           output int unsigned value);
    int unsigned lim;
    value = 0;
    if ((sel == TBL_SLOT_MAP || sel == TBL_ROW_PTRS || sel == TBL_SLOT_COLS) && !sh_built)
      return ST_NOT_BUILT;
    case (sel)
      TBL_ROW_OFFS, TBL_COL_OFFS, TBL_PAIR_OFFS: lim = sh_elems + 1;
      TBL_ROWS:      lim = sh_roffs[sh_elems] + sh_open_rows;
      TBL_COLS:      lim = sh_coffs[sh_elems] + sh_open_cols;
      TBL_SLOT_MAP:  lim = sh_poffs[sh_elems];
      TBL_ROW_PTRS:  lim = sh_row_count + 1;
      TBL_SLOT_COLS: lim = sh_unique;
      TBL_MAXIMA, TBL_COUNTS: lim = 3;
      default:       lim = 0;
    endcase
    if (idx >= lim) return ST_READ_RANGE;
    case (sel)
      TBL_ROW_OFFS:  value = sh_roffs[idx];
      TBL_ROWS:      value = sh_rows[idx];
      TBL_COL_OFFS:  value = sh_coffs[idx];
      TBL_COLS:      value = sh_cols[idx];
      TBL_PAIR_OFFS: value = sh_poffs[idx];
      TBL_SLOT_MAP:  value = sh_slot_of_pair[idx];
      TBL_ROW_PTRS:  value = sh_rptr[idx];
      TBL_SLOT_COLS: value = sh_slot_col[idx];
      TBL_MAXIMA:    value = sh_max[idx];
      default:       value = (idx == 0) ? sh_elems : (idx == 1) ? sh_poffs[sh_elems] : sh_unique;
    endcase
    return ST_OK;
  endfunction

  function automatic rsp_t map_predict(req_t r);
    rsp_t o;
    int unsigned value, st, lim, total, pairs, e;
    value = 0; st = ST_OK;
    case (r.req_type)
      REQ_ADD_ROW, REQ_ADD_COL: begin
        lim   = (r.req_type == REQ_ADD_ROW) ? sh_row_count : sh_col_count;
        total = (r.req_type == REQ_ADD_ROW) ? sh_roffs[sh_elems] + sh_open_rows
                                            : sh_coffs[sh_elems] + sh_open_cols;
        if (r.dof_index >= lim) begin
          sh_err = 1'b1; st = ST_RANGE;
        end else if (total >= MAX_LIST) begin
          sh_err = 1'b1; st = ST_CAPACITY;
        end else begin
          if (r.req_type == REQ_ADD_ROW) begin
            sh_rows[total] = r.dof_index; sh_open_rows++;
          end else begin
            sh_cols[total] = r.dof_index; sh_open_cols++;
          end
          sh_built = 1'b0;
        end
      end
      REQ_CLOSE: begin
        pairs = sh_open_rows * sh_open_cols;
        sh_built = 1'b0;
        if (sh_elems >= MAX_ELEMENTS || sh_poffs[sh_elems] + pairs > MAX_PAIRS) begin
          sh_err = 1'b1; st = ST_CAPACITY;
        end else begin
          e = sh_elems;
          sh_roffs[e+1] = sh_roffs[e] + sh_open_rows;
          sh_coffs[e+1] = sh_coffs[e] + sh_open_cols;
          sh_poffs[e+1] = sh_poffs[e] + pairs;
          if (sh_open_rows > sh_max[0]) sh_max[0] = sh_open_rows;
          if (sh_open_cols > sh_max[1]) sh_max[1] = sh_open_cols;
          if (pairs > sh_max[2]) sh_max[2] = pairs;
          sh_elems++;
          sh_open_rows = 0; sh_open_cols = 0;
        end
      end
      REQ_BUILD: begin
        sh_built = 1'b0;
        st = map_build(value);
      end
      REQ_READ:  st = map_read(r.table_select, r.read_index, value);
      REQ_CLEAR: map_clear();
      default: ;
    endcase
    o.read_value = (st != ST_OK) ? '0 : value[PTR_W-1:0];
    o.status     = st[2:0];
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Valid stays up between back-to-back transactions; it is
  // dropped only at the start of an idle burst or when draining.
  // --------------------------------------------------------------------------
  task automatic send_req(logic [2:0] rt, int unsigned dof = 0,
                          logic [3:0] sel = 0, int unsigned idx = 0);
    req_t r;
    bit   rdy;
    int   gap;
    r.req_type = rt;
    r.dof_index = dof[DOF_W-1:0];
    r.table_select = sel;
    r.read_index = idx[PTR_W-1:0];
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    pending_rsp.push_back(map_predict(r));
    sent_count++;
    // ready is stable from the falling edge until the next rising edge
    do begin
      @(negedge clk);
      rdy = req_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Let every owed response come back, then idle with valid low.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int unsigned value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_COUNT) sh_row_count = value[CNT_W-1:0];
    else sh_col_count = value[CNT_W-1:0];
    sh_built = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stall bursts, checked at the falling edge where the
  // handshake is stable.
  // --------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if (!quiet && !rst && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 16);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response value=%0d status=%0d",
                 $time, rsp.read_value, rsp.status);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, want.read_value, rsp.read_value);
          fail_count++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, rsp.status);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Two overlapping elements, build with merge, reads of every table,
  // edges of the read range and the spare request codes.
  task automatic test_basic_build();
    write_cfg(CFG_ROW_COUNT, 8);
    write_cfg(CFG_COL_COUNT, 8);
    send_req(REQ_READ, 0, TBL_SLOT_MAP, 0);    // not built yet
    send_req(REQ_ADD_ROW, 0);
    send_req(REQ_ADD_ROW, 7);
    send_req(REQ_ADD_COL, 3);
    send_req(REQ_ADD_COL, 7);
    send_req(REQ_CLOSE);
    send_req(REQ_ADD_ROW, 7);
    send_req(REQ_ADD_COL, 7);
    send_req(REQ_ADD_COL, 0);
    send_req(REQ_CLOSE);
    send_req(REQ_CLOSE);                       // empty element
    send_req(REQ_ADD_ROW, 2);                  // left unclosed, not built
    send_req(REQ_BUILD);
    for (int s = TBL_ROW_OFFS; s <= TBL_COUNTS; s++)
      for (int i = 0; i < 4; i++) send_req(REQ_READ, 0, s, i);
    send_req(REQ_READ, 0, TBL_ROW_PTRS, 8);
    send_req(REQ_READ, 0, TBL_ROW_PTRS, 9);
    send_req(REQ_READ, 0, TBL_SLOT_MAP, 5);
    send_req(REQ_READ, 0, TBL_COUNTS, 32767);
    send_req(REQ_READ, 0, TBL_NONE, 0);
    send_req(REQ_READ, 0, 4'hF, 0);
    send_req(REQ_SPARE_A, 4095, 4'hF, 32767);
    send_req(REQ_SPARE_B);
    send_req(REQ_ADD_COL, 1);                  // successful add makes the build stale
    send_req(REQ_READ, 0, TBL_SLOT_COLS, 0);
  endtask

  // Bad indices and the three ways a build is refused.
  task automatic test_build_refusal();
    send_req(REQ_CLEAR);
    send_req(REQ_ADD_ROW, 8);                  // row out of range
    send_req(REQ_ADD_COL, 4095);
    send_req(REQ_BUILD);                       // error pending
    send_req(REQ_READ, 0, TBL_ROWS, 0);
    send_req(REQ_CLEAR);
    send_req(REQ_ADD_ROW, 5);
    send_req(REQ_ADD_COL, 5);
    send_req(REQ_CLOSE);
    write_cfg(CFG_ROW_COUNT, 4);               // stored row now out of range
    send_req(REQ_BUILD);
    send_req(REQ_CLEAR);
    write_cfg(CFG_ROW_COUNT, 8191);            // above the row limit
    send_req(REQ_BUILD);
    send_req(REQ_CLEAR);
    write_cfg(CFG_ROW_COUNT, 0);
    write_cfg(CFG_COL_COUNT, 0);
    send_req(REQ_ADD_ROW, 0);
    send_req(REQ_CLEAR);
    send_req(REQ_BUILD);                       // empty build with zero counts
    send_req(REQ_READ, 0, TBL_ROW_PTRS, 0);
    send_req(REQ_READ, 0, TBL_ROW_PTRS, 1);
  endtask

  // List full, too many elements, too many pairs.
  task automatic test_capacity();
    write_cfg(CFG_ROW_COUNT, 4096);
    write_cfg(CFG_COL_COUNT, 4096);
    send_req(REQ_CLEAR);
    for (int i = 0; i < MAX_LIST; i++) send_req(REQ_ADD_ROW, i);
    send_req(REQ_ADD_ROW, 1);
    send_req(REQ_READ, 0, TBL_ROWS, MAX_LIST - 1);
    send_req(REQ_READ, 0, TBL_ROWS, MAX_LIST);
    send_req(REQ_CLEAR);
    for (int i = 0; i <= MAX_ELEMENTS; i++) send_req(REQ_CLOSE);
    send_req(REQ_READ, 0, TBL_COUNTS, 0);
    send_req(REQ_READ, 0, TBL_ROW_OFFS, MAX_ELEMENTS);
    send_req(REQ_CLEAR);
    for (int i = 0; i < 128; i++) send_req(REQ_ADD_ROW, 4095 - i);
    for (int i = 0; i < 129; i++) send_req(REQ_ADD_COL, i);
    send_req(REQ_CLOSE);                       // 16512 pairs, refused
    send_req(REQ_READ, 0, TBL_MAXIMA, 2);
    send_req(REQ_READ, 0, TBL_COLS, 128);
    send_req(REQ_BUILD);
  endtask

  function automatic int unsigned pick_count();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(1, 4);
      1:       return 4096;
      2:       return $urandom_range(1, 4095);
      3:       return $urandom_range(5, 40);
      default: return $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
    endcase
  endfunction

  function automatic int unsigned pick_dof(int unsigned lim);
    if (lim > 0 && $urandom_range(0, 19) != 0)
      return $urandom_range(0, (lim > 4096 ? 4096 : lim) - 1);
    return $urandom_range(0, 4095);
  endfunction

  // One load/build/read cycle with random content and the odd broken request.
  task automatic run_episode();
    int unsigned n_el, nr, nc, sel, idx;
    write_cfg(CFG_ROW_COUNT, pick_count());
    write_cfg(CFG_COL_COUNT, pick_count());
    send_req(REQ_CLEAR);
    n_el = $urandom_range(1, 8);
    for (int e = 0; e < n_el; e++) begin
      nr = $urandom_range(0, 5);
      nc = $urandom_range(0, 5);
      for (int i = 0; i < nr; i++) send_req(REQ_ADD_ROW, pick_dof(sh_row_count));
      for (int i = 0; i < nc; i++) send_req(REQ_ADD_COL, pick_dof(sh_col_count));
      if ($urandom_range(0, 9) == 0)
        send_req($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
                 $urandom, $urandom, $urandom);
      send_req(REQ_CLOSE);
    end
    if ($urandom_range(0, 3) == 0) send_req(REQ_ADD_COL, pick_dof(sh_col_count));
    send_req(REQ_BUILD);
    repeat ($urandom_range(10, 24)) begin
      sel = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
      case ($urandom_range(0, 5))
        0:       idx = $urandom_range(0, 32767);
        1:       idx = $urandom_range(0, sh_row_count + 2);
        default: idx = $urandom_range(0, 30);
      endcase
      send_req(REQ_READ, 0, sel, idx);
    end
  endtask

  task automatic test_random();
    int start_count;
    start_count = sent_count;
    while (sent_count - start_count < 750) begin
      if (sent_count - start_count > 650) quiet = 1'b1;
      run_episode();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data = '0;
    sh_row_count = 0;
    sh_col_count = 0;
    map_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_build();
    test_build_refusal();
    test_capacity();
    test_random();

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
